// ===== src/tccc_pkg.sv =====
`default_nettype none

package tccc_pkg;

    // Screen size limits and register reset values.
    localparam int          COLUMN_LIMIT = 256;
    localparam int          ROW_LIMIT    = 128;
    localparam logic [8:0]  COLS_RESET   = 9'd80;
    localparam logic [7:0]  ROWS_RESET   = 8'd25;
    localparam logic [3:0]  FG_RESET     = 4'd7;
    localparam logic [3:0]  BG_RESET     = 4'd0;

    // Configuration register indexes.
    localparam logic CFG_COLUMNS = 1'b0;
    localparam logic CFG_ROWS    = 1'b1;

    // Command op codes.
    localparam logic [2:0] OP_PUT_CHAR  = 3'd0;
    localparam logic [2:0] OP_ERASE     = 3'd1;
    localparam logic [2:0] OP_CLEAR     = 3'd2;
    localparam logic [2:0] OP_SET_COLOR = 3'd3;
    localparam logic [2:0] OP_SWITCH    = 3'd4;

    // Result kinds.
    localparam logic [2:0] KIND_CELL   = 3'd0;
    localparam logic [2:0] KIND_SCROLL = 3'd1;
    localparam logic [2:0] KIND_CLEAR  = 3'd2;
    localparam logic [2:0] KIND_CURSOR = 3'd3;
    localparam logic [2:0] KIND_REDRAW = 3'd4;

    // Control characters and the fill character.
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_RETURN  = 8'h0D;
    localparam logic [7:0] CHAR_LEFT    = 8'h08;
    localparam logic [7:0] CHAR_RIGHT   = 8'h0E;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;

    // Character classes found by the front end.
    localparam logic [2:0] CC_PRINT   = 3'd0;
    localparam logic [2:0] CC_NEWLINE = 3'd1;
    localparam logic [2:0] CC_RETURN  = 3'd2;
    localparam logic [2:0] CC_LEFT    = 3'd3;
    localparam logic [2:0] CC_RIGHT   = 3'd4;

    // Classified command as it sits in the queue.
    typedef struct packed {
        logic [2:0] op;
        logic [2:0] char_class;
        logic [7:0] char_code;
        logic [7:0] color_attr;
        logic [1:0] target;
    } cmd_t;

    // One result word.
    typedef struct packed {
        logic [2:0] kind;
        logic [1:0] terminal;
        logic [6:0] row;
        logic [7:0] column;
        logic [7:0] cell_char;
        logic [3:0] foreground;
        logic [3:0] background;
        logic       last;
    } result_t;

endpackage

`default_nettype wire

// ===== src/tccc_front.sv =====
`default_nettype none

module tccc_front (
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire logic [2:0]     s_op,
    input  wire logic [7:0]     s_char_code,
    input  wire logic [7:0]     s_color_attr,
    input  wire logic [1:0]     s_target_terminal,
    input  wire logic           q_full,
    output logic                q_push,
    output tccc_pkg::cmd_t      q_cmd
);

    logic op_known;
    logic [2:0] char_class;

    // Sort the character into control codes and printable output.
    always_comb begin
        unique case (s_char_code)
            tccc_pkg::CHAR_NEWLINE: char_class = tccc_pkg::CC_NEWLINE;
            tccc_pkg::CHAR_RETURN:  char_class = tccc_pkg::CC_RETURN;
            tccc_pkg::CHAR_LEFT:    char_class = tccc_pkg::CC_LEFT;
            tccc_pkg::CHAR_RIGHT:   char_class = tccc_pkg::CC_RIGHT;
            default:                char_class = tccc_pkg::CC_PRINT;
        endcase
    end

    // Unused op codes are accepted and dropped here.
    assign op_known = (s_op <= tccc_pkg::OP_SWITCH);

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full && op_known;

    always_comb begin
        q_cmd.op         = s_op;
        q_cmd.char_class = char_class;
        q_cmd.char_code  = s_char_code;
        q_cmd.color_attr = s_color_attr;
        q_cmd.target     = s_target_terminal;
    end

endmodule

`default_nettype wire

// ===== src/tccc_queue.sv =====
`default_nettype none

module tccc_queue #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic                  empty,
    output logic [WIDTH-1:0]      rdata
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rdata   = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CW'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

// ===== src/tccc_back.sv =====
`default_nettype none

module tccc_back #(
    parameter int TERMINALS = 4
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           cfg_we,
    input  wire logic           cfg_index,
    input  wire logic [8:0]     cfg_wdata,
    input  wire logic           q_valid,
    input  wire tccc_pkg::cmd_t q_cmd,
    output logic                q_pop,
    output logic                m_valid,
    input  wire logic           m_ready,
    output tccc_pkg::result_t   m_result
);

    localparam int TW = (TERMINALS > 1) ? $clog2(TERMINALS) : 1;

    // Per-terminal cursor and colors, active terminal, screen size.
    logic [7:0]    col_reg [TERMINALS];
    logic [6:0]    row_reg [TERMINALS];
    logic [3:0]    fg_reg  [TERMINALS];
    logic [3:0]    bg_reg  [TERMINALS];
    logic [TW-1:0] active_reg;
    logic [8:0]    cols_cfg_reg;
    logic [7:0]    rows_cfg_reg;

    // Result buffer: word 0 is on the output.
    tccc_pkg::result_t res_reg [3];
    tccc_pkg::result_t res_next [3];
    logic [1:0]        cnt_reg, cnt_next;

    logic [8:0]    ecols;
    logic [7:0]    erows;
    logic [TW-1:0] idx;
    logic [7:0]    cur_col, cl_col;
    logic [6:0]    cur_row, cl_row;
    logic [3:0]    cur_fg, cur_bg;
    logic [1:0]    term;
    logic          take, load;
    logic          wr_pos, wr_color, wr_active;
    logic [7:0]    new_col;
    logic [6:0]    new_row;
    logic [8:0]    x;
    logic [7:0]    y;
    logic          has_cell, has_scroll;
    logic          sw_ok;
    logic [1:0]    n;

    function automatic tccc_pkg::result_t make_res(
        input logic [2:0] kind,
        input logic [1:0] terminal,
        input logic [6:0] row,
        input logic [7:0] column,
        input logic [7:0] cell_char,
        input logic [3:0] fg,
        input logic [3:0] bg
    );
        tccc_pkg::result_t r;
        r.kind       = kind;
        r.terminal   = terminal;
        r.row        = row;
        r.column     = column;
        r.cell_char  = cell_char;
        r.foreground = fg;
        r.background = bg;
        r.last       = 1'b0;
        return r;
    endfunction

    // Effective screen size: zero counts as one, large values saturate.
    always_comb begin
        if (cols_cfg_reg == '0) begin
            ecols = 9'd1;
        end else if (int'(cols_cfg_reg) > tccc_pkg::COLUMN_LIMIT) begin
            ecols = 9'(tccc_pkg::COLUMN_LIMIT);
        end else begin
            ecols = cols_cfg_reg;
        end
        if (rows_cfg_reg == '0) begin
            erows = 8'd1;
        end else if (int'(rows_cfg_reg) > tccc_pkg::ROW_LIMIT) begin
            erows = 8'(tccc_pkg::ROW_LIMIT);
        end else begin
            erows = rows_cfg_reg;
        end
    end

    // Switch reads the target terminal, everything else the active one.
    assign idx     = (q_cmd.op == tccc_pkg::OP_SWITCH) ? TW'(q_cmd.target) : active_reg;
    assign term    = 2'(idx);
    assign cur_col = col_reg[idx];
    assign cur_row = row_reg[idx];
    assign cur_fg  = fg_reg[idx];
    assign cur_bg  = bg_reg[idx];
    assign cl_col  = ({1'b0, cur_col} >= ecols) ? 8'(ecols - 9'd1) : cur_col;
    assign cl_row  = ({1'b0, cur_row} >= erows) ? 7'(erows - 8'd1) : cur_row;
    assign sw_ok   = (int'(q_cmd.target) < TERMINALS)
                     && (int'(q_cmd.target) != int'(active_reg));

    // Execute one command and build its result list.
    always_comb begin
        res_next[0] = res_reg[0];
        res_next[1] = res_reg[1];
        res_next[2] = res_reg[2];
        n          = 2'd0;
        x          = {1'b0, cl_col};
        y          = {1'b0, cl_row};
        has_cell   = 1'b0;
        has_scroll = 1'b0;
        wr_pos     = 1'b0;
        wr_color   = 1'b0;
        wr_active  = 1'b0;
        unique case (q_cmd.op)
            tccc_pkg::OP_PUT_CHAR: begin
                case (q_cmd.char_class)
                    tccc_pkg::CC_NEWLINE: begin
                        x = '0;
                        y = y + 8'd1;
                    end
                    tccc_pkg::CC_RETURN: begin
                        x = '0;
                    end
                    tccc_pkg::CC_LEFT: begin
                        if (x != '0) begin
                            x = x - 9'd1;
                        end
                    end
                    tccc_pkg::CC_RIGHT: begin
                        if (x + 9'd1 < ecols) begin
                            x = x + 9'd1;
                        end
                    end
                    default: begin
                        has_cell = 1'b1;
                        x        = x + 9'd1;
                    end
                endcase
                // Wrap at the line end, scroll at the bottom.
                if (x >= ecols) begin
                    x = '0;
                    y = y + 8'd1;
                end
                if (y >= erows) begin
                    has_scroll = 1'b1;
                    y          = erows - 8'd1;
                    x          = '0;
                end
                wr_pos = 1'b1;
                if (has_cell) begin
                    res_next[n] = make_res(tccc_pkg::KIND_CELL, term, cl_row, cl_col,
                                           q_cmd.char_code, cur_fg, cur_bg);
                    n = n + 2'd1;
                end
                if (has_scroll) begin
                    res_next[n] = make_res(tccc_pkg::KIND_SCROLL, term, '0, '0, '0,
                                           cur_fg, cur_bg);
                    n = n + 2'd1;
                end
                res_next[n] = make_res(tccc_pkg::KIND_CURSOR, term, y[6:0], x[7:0], '0,
                                       cur_fg, cur_bg);
                n = n + 2'd1;
            end
            tccc_pkg::OP_ERASE: begin
                // The clamped position is kept even at home.
                wr_pos = 1'b1;
                if (cl_col != '0 || cl_row != '0) begin
                    if (cl_col != '0) begin
                        x = x - 9'd1;
                    end else begin
                        y = y - 8'd1;
                        x = ecols - 9'd1;
                    end
                    res_next[0] = make_res(tccc_pkg::KIND_CELL, term, y[6:0], x[7:0],
                                           tccc_pkg::CHAR_SPACE, cur_fg, cur_bg);
                    res_next[1] = make_res(tccc_pkg::KIND_CURSOR, term, y[6:0], x[7:0],
                                           '0, cur_fg, cur_bg);
                    n = 2'd2;
                end
            end
            tccc_pkg::OP_CLEAR: begin
                wr_pos = 1'b1;
                x      = '0;
                y      = '0;
                res_next[0] = make_res(tccc_pkg::KIND_CLEAR, term, '0, '0,
                                       tccc_pkg::CHAR_SPACE, cur_fg, cur_bg);
                res_next[1] = make_res(tccc_pkg::KIND_CURSOR, term, '0, '0, '0,
                                       cur_fg, cur_bg);
                n = 2'd2;
            end
            tccc_pkg::OP_SET_COLOR: begin
                wr_color = 1'b1;
            end
            tccc_pkg::OP_SWITCH: begin
                if (sw_ok) begin
                    wr_pos    = 1'b1;
                    wr_active = 1'b1;
                    res_next[0] = make_res(tccc_pkg::KIND_REDRAW, term, '0, '0, '0,
                                           cur_fg, cur_bg);
                    res_next[1] = make_res(tccc_pkg::KIND_CURSOR, term, cl_row, cl_col,
                                           '0, cur_fg, cur_bg);
                    n = 2'd2;
                end
            end
            default: begin
            end
        endcase
        if (n != 2'd0) begin
            res_next[n - 2'd1].last = 1'b1;
        end
    end

    assign new_col = x[7:0];
    assign new_row = y[6:0];

    // A new command loads when the buffer is empty or as its last word leaves.
    assign m_valid  = (cnt_reg != 2'd0);
    assign m_result = res_reg[0];
    assign take     = m_valid && m_ready;
    assign load     = q_valid && ((cnt_reg == 2'd0) || (cnt_reg == 2'd1 && take));
    assign q_pop    = load;

    always_comb begin
        cnt_next = cnt_reg;
        if (load) begin
            cnt_next = n;
        end else if (take) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    // Control state, terminal state and configuration.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg      <= '0;
            active_reg   <= '0;
            cols_cfg_reg <= tccc_pkg::COLS_RESET;
            rows_cfg_reg <= tccc_pkg::ROWS_RESET;
            for (int i = 0; i < TERMINALS; i++) begin
                col_reg[i] <= '0;
                row_reg[i] <= '0;
                fg_reg[i]  <= tccc_pkg::FG_RESET;
                bg_reg[i]  <= tccc_pkg::BG_RESET;
            end
        end else begin
            cnt_reg <= cnt_next;
            if (cfg_we) begin
                if (cfg_index == tccc_pkg::CFG_COLUMNS) begin
                    cols_cfg_reg <= cfg_wdata;
                end else begin
                    rows_cfg_reg <= cfg_wdata[7:0];
                end
            end
            if (load) begin
                if (wr_pos) begin
                    col_reg[idx] <= new_col;
                    row_reg[idx] <= new_row;
                end
                if (wr_color) begin
                    fg_reg[idx] <= q_cmd.color_attr[3:0];
                    bg_reg[idx] <= q_cmd.color_attr[7:4];
                end
                if (wr_active) begin
                    active_reg <= idx;
                end
            end
        end
    end

    // Result words shift toward the output.
    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg[0] <= res_next[0];
            res_reg[1] <= res_next[1];
            res_reg[2] <= res_next[2];
        end else if (take) begin
            res_reg[0] <= res_reg[1];
            res_reg[1] <= res_reg[2];
        end
    end

endmodule

`default_nettype wire

// ===== src/text_terminal_cursor_controller_top.sv =====
// Channel   Direction  Handshake          Word
// cfg       in         cfg_we             cfg_index, cfg_wdata (columns, rows)
// s_        in         s_valid/s_ready    op, char_code, color_attr, target_terminal
// m_        out        m_valid/m_ready    kind, terminal, row, column, cell_char,
//                                         foreground, background, last
//
// The executor loads a command when its result buffer is empty or as its last word
// leaves. Put character gives one to three result words, erase and switch two or
// none, clear two, set color none. Unused op codes are dropped by the decoder.
// A command waits in the queue, then loads into the result buffer and is offered.
// A two-word command queue lets input be taken while results wait for m_ready.
// Reset is synchronous on aresetn and restores the 80 by 25 screen and defaults.

`default_nettype none

module text_terminal_cursor_controller_top #(
    parameter int TERMINALS = 4
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_we,
    input  wire logic       cfg_index,
    input  wire logic [8:0] cfg_wdata,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [2:0] s_op,
    input  wire logic [7:0] s_char_code,
    input  wire logic [7:0] s_color_attr,
    input  wire logic [1:0] s_target_terminal,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [2:0]      m_kind,
    output logic [1:0]      m_terminal,
    output logic [6:0]      m_row,
    output logic [7:0]      m_column,
    output logic [7:0]      m_cell_char,
    output logic [3:0]      m_foreground,
    output logic [3:0]      m_background,
    output logic            m_last
);

    localparam int CMD_W = $bits(tccc_pkg::cmd_t);

    tccc_pkg::cmd_t    push_cmd;
    tccc_pkg::cmd_t    head_cmd;
    tccc_pkg::result_t result;
    logic              q_push, q_full, q_pop, q_empty;

    // Decoder.
    tccc_front u_front (
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_op              (s_op),
        .s_char_code       (s_char_code),
        .s_color_attr      (s_color_attr),
        .s_target_terminal (s_target_terminal),
        .q_full            (q_full),
        .q_push            (q_push),
        .q_cmd             (push_cmd)
    );

    // Command queue.
    tccc_queue #(
        .WIDTH (CMD_W),
        .DEPTH (2)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   (push_cmd),
        .full    (q_full),
        .pop     (q_pop),
        .empty   (q_empty),
        .rdata   (head_cmd)
    );

    // Executor.
    tccc_back #(
        .TERMINALS (TERMINALS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .q_valid   (!q_empty),
        .q_cmd     (head_cmd),
        .q_pop     (q_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_result  (result)
    );

    assign m_kind       = result.kind;
    assign m_terminal   = result.terminal;
    assign m_row        = result.row;
    assign m_column     = result.column;
    assign m_cell_char  = result.cell_char;
    assign m_foreground = result.foreground;
    assign m_background = result.background;
    assign m_last       = result.last;

endmodule

`default_nettype wire

// ===== src/tccc_checker.sv =====
`default_nettype none

module tccc_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       cfg_we,
    input wire logic       cfg_index,
    input wire logic [8:0] cfg_wdata,
    input wire logic       s_valid,
    input wire logic       s_ready,
    input wire logic [2:0] s_op,
    input wire logic [7:0] s_char_code,
    input wire logic [7:0] s_color_attr,
    input wire logic [1:0] s_target_terminal,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [2:0] m_kind,
    input wire logic [1:0] m_terminal,
    input wire logic [6:0] m_row,
    input wire logic [7:0] m_column,
    input wire logic [7:0] m_cell_char,
    input wire logic [3:0] m_foreground,
    input wire logic [3:0] m_background,
    input wire logic       m_last
);

    // No result word is offered in the cycle after reset.
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // A stalled result word holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_kind) && $stable(m_row)
            && $stable(m_column) && $stable(m_last))
        else $error("stalled result word changed");

    // Every command ends with the cursor position.
    a_cursor_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_kind == tccc_pkg::KIND_CURSOR) |-> m_last)
        else $error("cursor position not final");

    // Scroll, clear and redraw are always followed by a cursor position.
    a_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && ((m_kind == tccc_pkg::KIND_SCROLL) || (m_kind == tccc_pkg::KIND_REDRAW)
            || (m_kind == tccc_pkg::KIND_CLEAR)) |-> !m_last)
        else $error("command ended without cursor position");

    // Clear fills with spaces from the home position.
    a_clear_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_kind == tccc_pkg::KIND_CLEAR) |->
            (m_row == '0) && (m_column == '0) && (m_cell_char == tccc_pkg::CHAR_SPACE))
        else $error("malformed clear word");

endmodule

bind text_terminal_cursor_controller_top tccc_checker u_tccc_checker (.*);

`default_nettype wire

// ===== tb/testbench.sv =====
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_TERMINALS   = 4;
    localparam int CLK_HALF        = 10;
    localparam int RESET_CYCLES    = 4;
    localparam int SETTLE_CYCLES   = 8;
    localparam int NUM_PHASES      = 12;
    localparam int ITEMS_PER_PHASE = 30;

    // Op codes the block decodes as no operation.
    localparam logic [2:0] OP_UNUSED_LO = 3'd5;
    localparam logic [2:0] OP_UNUSED_HI = 3'd7;

    // Screen-state tracker: follows every terminal's cursor and colors and
    // holds the result words that the block still owes.
    class screen_scoreboard;
        tccc_pkg::result_t owed_words[$];
        int         failures;
        logic [8:0] columns_reg;
        logic [7:0] rows_reg;
        logic [7:0] cursor_col[NUM_TERMINALS];
        logic [6:0] cursor_row[NUM_TERMINALS];
        logic [3:0] fg_color[NUM_TERMINALS];
        logic [3:0] bg_color[NUM_TERMINALS];
        logic [1:0] active_term;

        function new();
            failures    = 0;
            columns_reg = tccc_pkg::COLS_RESET;
            rows_reg    = tccc_pkg::ROWS_RESET;
            active_term = '0;
            for (int t = 0; t < NUM_TERMINALS; t++) begin
                cursor_col[t] = '0;
                cursor_row[t] = '0;
                fg_color[t]   = tccc_pkg::FG_RESET;
                bg_color[t]   = tccc_pkg::BG_RESET;
            end
        endfunction

        function int pending();
            return owed_words.size();
        endfunction

        // Register values of zero act as one; oversized values saturate.
        function int screen_columns();
            if (columns_reg == 0) return 1;
            if (columns_reg > tccc_pkg::COLUMN_LIMIT) return tccc_pkg::COLUMN_LIMIT;
            return int'(columns_reg);
        endfunction

        function int screen_rows();
            if (rows_reg == 0) return 1;
            if (rows_reg > tccc_pkg::ROW_LIMIT) return tccc_pkg::ROW_LIMIT;
            return int'(rows_reg);
        endfunction

        // Pull a cursor back onto the screen after the screen shrank.
        function void clamp_to_screen(int t);
            if (cursor_col[t] >= screen_columns()) cursor_col[t] = 8'(screen_columns() - 1);
            if (cursor_row[t] >= screen_rows()) cursor_row[t] = 7'(screen_rows() - 1);
        endfunction

        function void add_word(logic [2:0] kind, int t, int row, int col, logic [7:0] code);
            tccc_pkg::result_t w;
            w.kind       = kind;
            w.terminal   = t[1:0];
            w.row        = row[6:0];
            w.column     = col[7:0];
            w.cell_char  = code;
            w.foreground = fg_color[t];
            w.background = bg_color[t];
            w.last       = 1'b0;
            owed_words.push_back(w);
        endfunction

        function void note_config(logic index, logic [8:0] value);
            if (index == tccc_pkg::CFG_COLUMNS) begin
                columns_reg = value;
            end else begin
                rows_reg = value[7:0];
            end
        endfunction

        // Work out the words that one accepted command causes.
        function void note_command(logic [2:0] op, logic [7:0] code, logic [7:0] attr,
                                   logic [1:0] target);
            int term;
            int cols;
            int rows;
            int cx;
            int cy;
            int first;
            term  = int'(active_term);
            cols  = screen_columns();
            rows  = screen_rows();
            first = owed_words.size();
            case (op)
                tccc_pkg::OP_PUT_CHAR: begin
                    clamp_to_screen(term);
                    cx = int'(cursor_col[term]);
                    cy = int'(cursor_row[term]);
                    if (code == tccc_pkg::CHAR_NEWLINE) begin
                        cx = 0;
                        cy++;
                    end else if (code == tccc_pkg::CHAR_RETURN) begin
                        cx = 0;
                    end else if (code == tccc_pkg::CHAR_LEFT) begin
                        if (cx > 0) cx--;
                    end else if (code == tccc_pkg::CHAR_RIGHT) begin
                        if (cx + 1 < cols) cx++;
                    end else begin
                        add_word(tccc_pkg::KIND_CELL, term, cy, cx, code);
                        cx++;
                    end
                    // Wrap at the line end, scroll at the bottom.
                    if (cx >= cols) begin
                        cx = 0;
                        cy++;
                    end
                    if (cy >= rows) begin
                        add_word(tccc_pkg::KIND_SCROLL, term, 0, 0, 8'h00);
                        cy = rows - 1;
                        cx = 0;
                    end
                    cursor_col[term] = 8'(cx);
                    cursor_row[term] = 7'(cy);
                    add_word(tccc_pkg::KIND_CURSOR, term, cy, cx, 8'h00);
                end
                tccc_pkg::OP_ERASE: begin
                    clamp_to_screen(term);
                    cx = int'(cursor_col[term]);
                    cy = int'(cursor_row[term]);
                    // Nothing to erase at the home position.
                    if (cx == 0 && cy == 0) return;
                    if (cx > 0) begin
                        cx--;
                    end else begin
                        cy--;
                        cx = cols - 1;
                    end
                    cursor_col[term] = 8'(cx);
                    cursor_row[term] = 7'(cy);
                    add_word(tccc_pkg::KIND_CELL, term, cy, cx, tccc_pkg::CHAR_SPACE);
                    add_word(tccc_pkg::KIND_CURSOR, term, cy, cx, 8'h00);
                end
                tccc_pkg::OP_CLEAR: begin
                    cursor_col[term] = '0;
                    cursor_row[term] = '0;
                    add_word(tccc_pkg::KIND_CLEAR, term, 0, 0, tccc_pkg::CHAR_SPACE);
                    add_word(tccc_pkg::KIND_CURSOR, term, 0, 0, 8'h00);
                end
                tccc_pkg::OP_SET_COLOR: begin
                    fg_color[term] = attr[3:0];
                    bg_color[term] = attr[7:4];
                end
                tccc_pkg::OP_SWITCH: begin
                    if (target == term || target >= NUM_TERMINALS) return;
                    active_term = target;
                    clamp_to_screen(target);
                    add_word(tccc_pkg::KIND_REDRAW, target, 0, 0, 8'h00);
                    add_word(tccc_pkg::KIND_CURSOR, target, cursor_row[target],
                             cursor_col[target], 8'h00);
                end
                default: begin
                end
            endcase
            if (owed_words.size() > first) owed_words[owed_words.size() - 1].last = 1'b1;
        endfunction

        function void compare_field(string field, int want, int got);
            if (want != got) begin
                $error("%s mismatch: expected %0d, got %0d", field, want, got);
                failures++;
            end
        endfunction

        function void check_result(tccc_pkg::result_t got);
            tccc_pkg::result_t want;
            if (owed_words.size() == 0) begin
                $error("unexpected result word of kind %0d", got.kind);
                failures++;
                return;
            end
            want = owed_words.pop_front();
            compare_field("kind", want.kind, got.kind);
            compare_field("terminal", want.terminal, got.terminal);
            compare_field("row", want.row, got.row);
            compare_field("column", want.column, got.column);
            compare_field("cell_char", want.cell_char, got.cell_char);
            compare_field("foreground", want.foreground, got.foreground);
            compare_field("background", want.background, got.background);
            compare_field("last", want.last, got.last);
        endfunction
    endclass

    logic       aclk              = 1'b0;
    logic       aresetn           = 1'b0;
    logic       cfg_we            = 1'b0;
    logic       cfg_index         = 1'b0;
    logic [8:0] cfg_wdata         = '0;
    logic       s_valid           = 1'b0;
    logic       s_ready;
    logic [2:0] s_op              = '0;
    logic [7:0] s_char_code       = '0;
    logic [7:0] s_color_attr      = '0;
    logic [1:0] s_target_terminal = '0;
    logic       m_valid;
    logic       m_ready           = 1'b0;
    logic [2:0] m_kind;
    logic [1:0] m_terminal;
    logic [6:0] m_row;
    logic [7:0] m_column;
    logic [7:0] m_cell_char;
    logic [3:0] m_foreground;
    logic [3:0] m_background;
    logic       m_last;

    screen_scoreboard sb = new();
    bit quiet = 1'b0;
    int ready_hold = 0;

    // Screen sizes per phase; rows values above 255 exercise the 8-bit register.
    int phase_columns[NUM_PHASES] = '{0, 511, 3, 1, 40, 256, 2, 7, 257, 5, 17, 80};
    int phase_rows[NUM_PHASES]    = '{0, 511, 2, 1, 30, 128, 256, 4, 129, 3, 9, 25};

    text_terminal_cursor_controller_top #(
        .TERMINALS(NUM_TERMINALS)
    ) i_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_op              (s_op),
        .s_char_code       (s_char_code),
        .s_color_attr      (s_color_attr),
        .s_target_terminal (s_target_terminal),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_kind            (m_kind),
        .m_terminal        (m_terminal),
        .m_row             (m_row),
        .m_column          (m_column),
        .m_cell_char       (m_cell_char),
        .m_foreground      (m_foreground),
        .m_background      (m_background),
        .m_last            (m_last)
    );

    always #CLK_HALF aclk = ~aclk;

    // Mostly short gaps, now and then a long one; none in quiet phases.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Character mix: mostly printable text and cursor controls.
    function automatic logic [7:0] random_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 8'($urandom_range(8'h21, 8'h7E));
        if (r < 60) return tccc_pkg::CHAR_NEWLINE;
        if (r < 68) return tccc_pkg::CHAR_RETURN;
        if (r < 78) return tccc_pkg::CHAR_LEFT;
        if (r < 88) return tccc_pkg::CHAR_RIGHT;
        return 8'($urandom_range(0, 255));
    endfunction

    // Result side back-pressure.
    always @(posedge aclk) begin
        if (ready_hold > 0) begin
            m_ready    <= 1'b0;
            ready_hold <= ready_hold - 1;
        end else begin
            m_ready    <= 1'b1;
            ready_hold <= pick_gap();
        end
    end

    // Observe register writes, accepted commands and accepted result words.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_we) sb.note_config(cfg_index, cfg_wdata);
            if (s_valid && s_ready) begin
                sb.note_command(s_op, s_char_code, s_color_attr, s_target_terminal);
            end
            if (m_valid && m_ready) begin
                sb.check_result({m_kind, m_terminal, m_row, m_column, m_cell_char,
                                 m_foreground, m_background, m_last});
            end
        end
    end

    // Present one command word and hold it until it is taken.
    task automatic send_cmd(logic [2:0] op, logic [7:0] code, logic [7:0] attr,
                            logic [1:0] target);
        s_valid           <= 1'b1;
        s_op              <= op;
        s_char_code       <= code;
        s_color_attr      <= attr;
        s_target_terminal <= target;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic rest_sender(int cycles);
        if (cycles > 0) begin
            s_valid <= 1'b0;
            repeat (cycles) @(posedge aclk);
        end
    endtask

    task automatic issue(logic [2:0] op, logic [7:0] code, logic [7:0] attr,
                         logic [1:0] target);
        send_cmd(op, code, attr, target);
        rest_sender(pick_gap());
    endtask

    // Stop sending until every owed word has come, then let silent commands finish.
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic index, logic [8:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic random_command(output logic [2:0] op);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55) op = tccc_pkg::OP_PUT_CHAR;
        else if (pick < 67) op = tccc_pkg::OP_ERASE;
        else if (pick < 72) op = tccc_pkg::OP_CLEAR;
        else if (pick < 80) op = tccc_pkg::OP_SET_COLOR;
        else if (pick < 92) op = tccc_pkg::OP_SWITCH;
        else op = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
        issue(op, random_char(), 8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)));
    endtask

    // Directed opening on the default 80 by 25 screen.
    task automatic run_directed();
        issue(tccc_pkg::OP_SET_COLOR, 8'h00, 8'hFF, 2'd0);
        issue(tccc_pkg::OP_PUT_CHAR, 8'h41, 8'h00, 2'd0);
        issue(tccc_pkg::OP_PUT_CHAR, 8'hFF, 8'h00, 2'd0);
        issue(tccc_pkg::OP_PUT_CHAR, 8'h00, 8'h00, 2'd0);
        issue(tccc_pkg::OP_PUT_CHAR, tccc_pkg::CHAR_LEFT, 8'h00, 2'd0);
        issue(tccc_pkg::OP_PUT_CHAR, tccc_pkg::CHAR_RIGHT, 8'h00, 2'd0);
        issue(tccc_pkg::OP_PUT_CHAR, tccc_pkg::CHAR_RETURN, 8'h00, 2'd0);
        issue(tccc_pkg::OP_PUT_CHAR, tccc_pkg::CHAR_LEFT, 8'h00, 2'd0);
        issue(tccc_pkg::OP_PUT_CHAR, tccc_pkg::CHAR_NEWLINE, 8'h00, 2'd0);
        // Erase at column zero steps back onto the line above.
        issue(tccc_pkg::OP_ERASE, 8'h00, 8'h00, 2'd0);
        issue(tccc_pkg::OP_CLEAR, 8'hFF, 8'hFF, 2'd3);
        // Erase at home does nothing.
        issue(tccc_pkg::OP_ERASE, 8'h00, 8'h00, 2'd0);
        issue(tccc_pkg::OP_SET_COLOR, 8'h00, 8'h00, 2'd0);
        issue(tccc_pkg::OP_SET_COLOR, 8'h00, 8'h5A, 2'd0);
        // Switching to the active terminal is ignored.
        issue(tccc_pkg::OP_SWITCH, 8'h00, 8'h00, 2'd0);
        issue(tccc_pkg::OP_SWITCH, 8'h00, 8'h00, 2'd1);
        issue(tccc_pkg::OP_PUT_CHAR, 8'h7A, 8'h00, 2'd0);
        issue(tccc_pkg::OP_SWITCH, 8'h00, 8'h00, 2'd2);
        issue(tccc_pkg::OP_SWITCH, 8'h00, 8'h00, 2'd3);
        issue(tccc_pkg::OP_SWITCH, 8'h00, 8'h00, 2'd0);
        issue(OP_UNUSED_LO, 8'hFF, 8'hFF, 2'd3);
        issue(OP_UNUSED_LO + 3'd1, 8'h41, 8'hFF, 2'd1);
        issue(OP_UNUSED_HI, 8'hFF, 8'hFF, 2'd2);
        issue(tccc_pkg::OP_PUT_CHAR, 8'h80, 8'h3C, 2'd2);
    endtask

    initial begin
        int counted;
        logic [2:0] op;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        run_directed();
        // Random phases, each on its own screen size.
        for (int p = 0; p < NUM_PHASES; p++) begin
            drain_results();
            quiet = (p % 5 == 2);
            write_reg(tccc_pkg::CFG_COLUMNS, 9'(phase_columns[p]));
            write_reg(tccc_pkg::CFG_ROWS, 9'(phase_rows[p]));
            counted = 0;
            while (counted < ITEMS_PER_PHASE) begin
                random_command(op);
                if (op <= tccc_pkg::OP_SWITCH) counted++;
                if ($urandom_range(0, 49) == 0) drain_results();
            end
        end
        drain_results();
        if (sb.failures == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog far beyond the slowest legal run.
    initial begin
        #20ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
